FILE: rtl/btca_pkg.sv
// btca_pkg: shared types and constants for the binary time counter accumulator
// holds request codes, register indexes, controller steps and the command struct
// no dependencies
package btca_pkg;

   localparam int WORD_W         = 64;
   localparam int HALF_W         = 32;
   localparam int REQ_W          = 2;
   localparam int CSR_INDEX_W    = 2;
   localparam int NS_W           = 30;
   localparam int US_W           = 20;
   localparam int DEFAULT_COUNTER_WIDTH = 64;

   localparam logic [HALF_W-1:0] NS_SCALE = 32'd1000000000;
   localparam logic [HALF_W-1:0] US_SCALE = 32'd1000000;

   typedef enum logic [REQ_W-1:0] {
      REQ_TICK   = 2'd0,
      REQ_UPTIME = 2'd1,
      REQ_WALL   = 2'd2,
      REQ_LATCH  = 2'd3
   } req_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COUNTER_ENABLED = 2'd0,
      CSR_COUNTER_MASK    = 2'd1,
      CSR_FRAC_PER_COUNT  = 2'd2,
      CSR_BOOT_SECONDS    = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DELTA,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_SUM_FRAC,
      ST_SUM_SEC,
      ST_FINISH,
      ST_C0,
      ST_C1,
      ST_C2,
      ST_C3,
      ST_C4,
      ST_OUT
   } step_type;

   typedef enum logic [2:0] {
      MUL_LL,
      MUL_LH,
      MUL_HL,
      MUL_HH,
      MUL_NS_LO,
      MUL_NS_HI,
      MUL_US_LO,
      MUL_US_HI
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_CLEAR,
      ACC_ADD0,
      ACC_ADD32,
      ACC_ADD64
   } acc_op_type;

   typedef enum logic [2:0] {
      CVT_NONE,
      CVT_NS_LO,
      CVT_NS_HI,
      CVT_US_LO,
      CVT_US_HI
   } cvt_op_type;

   typedef struct packed {
      logic        capture;
      logic        delta;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        sum_frac;
      logic        sum_sec;
      logic        finish;
      cvt_op_type  cvt_op;
      logic        out_load;
   } cmd_type;

endpackage

FILE: rtl/btca_if.sv
// btca_req_if and btca_rsp_if: valid/ready channels for requests and results
// depends on btca_pkg for field widths
interface btca_req_if;
   import btca_pkg::*;
   logic                valid;
   logic                ready;
   logic [REQ_W-1:0]    req_type;
   logic [WORD_W-1:0]   counter_now;

   modport source (output valid, output req_type, output counter_now, input ready);
   modport sink (input valid, input req_type, input counter_now, output ready);
endinterface

interface btca_rsp_if;
   import btca_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   time_seconds;
   logic [WORD_W-1:0]   time_fraction;
   logic [NS_W-1:0]     nanoseconds;
   logic [US_W-1:0]     microseconds;

   modport source (output valid, output time_seconds, output time_fraction,
                   output nanoseconds, output microseconds, input ready);
   modport sink (input valid, input time_seconds, input time_fraction,
                 input nanoseconds, input microseconds, output ready);
endinterface

FILE: rtl/btca_ctrl.sv
// btca_ctrl: sequencer for one transaction through the shared multiplier
// depends on btca_pkg (step_type, cmd_type)
module btca_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output btca_pkg::cmd_type cmd
);
   import btca_pkg::*;

   step_type state_ff, state_in;
   logic     rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = MUL_LL;
      cmd.acc_op   = ACC_NONE;
      cmd.cvt_op   = CVT_NONE;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DELTA;
            end
         end
         ST_DELTA: begin
            cmd.delta  = 1'b1;
            cmd.acc_op = ACC_CLEAR;
            state_in   = ST_M0;
         end
         ST_M0: begin
            cmd.mul_sel = MUL_LL;
            state_in    = ST_M1;
         end
         ST_M1: begin
            cmd.mul_sel = MUL_LH;
            cmd.acc_op  = ACC_ADD0;
            state_in    = ST_M2;
         end
         ST_M2: begin
            cmd.mul_sel = MUL_HL;
            cmd.acc_op  = ACC_ADD32;
            state_in    = ST_M3;
         end
         ST_M3: begin
            cmd.mul_sel = MUL_HH;
            cmd.acc_op  = ACC_ADD32;
            state_in    = ST_M4;
         end
         ST_M4: begin
            cmd.acc_op = ACC_ADD64;
            state_in   = ST_SUM_FRAC;
         end
         ST_SUM_FRAC: begin
            cmd.sum_frac = 1'b1;
            state_in     = ST_SUM_SEC;
         end
         ST_SUM_SEC: begin
            cmd.sum_sec = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_C0;
         end
         ST_C0: begin
            cmd.mul_sel = MUL_NS_LO;
            state_in    = ST_C1;
         end
         ST_C1: begin
            cmd.mul_sel = MUL_NS_HI;
            cmd.cvt_op  = CVT_NS_LO;
            state_in    = ST_C2;
         end
         ST_C2: begin
            cmd.mul_sel = MUL_US_LO;
            cmd.cvt_op  = CVT_NS_HI;
            state_in    = ST_C3;
         end
         ST_C3: begin
            cmd.mul_sel = MUL_US_HI;
            cmd.cvt_op  = CVT_US_LO;
            state_in    = ST_C4;
         end
         ST_C4: begin
            cmd.cvt_op = CVT_US_HI;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/btca_datapath.sv
// btca_datapath: config registers, time state, shared 32x32 multiplier and sums
// depends on btca_pkg (cmd_type, codes, scale constants)
module btca_datapath #(
   parameter int COUNTER_WIDTH = btca_pkg::DEFAULT_COUNTER_WIDTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  btca_pkg::cmd_type               cmd,
   input  logic [btca_pkg::REQ_W-1:0]      in_req_type,
   input  logic [btca_pkg::WORD_W-1:0]     in_counter_now,
   input  logic                            csr_write_enable,
   input  logic [btca_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [btca_pkg::WORD_W-1:0]     csr_write_data,
   output logic [btca_pkg::WORD_W-1:0]     out_time_seconds,
   output logic [btca_pkg::WORD_W-1:0]     out_time_fraction,
   output logic [btca_pkg::NS_W-1:0]       out_nanoseconds,
   output logic [btca_pkg::US_W-1:0]       out_microseconds
);
   import btca_pkg::*;

   localparam logic [WORD_W-1:0] WidthMask = (COUNTER_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
      ((64'd1 << COUNTER_WIDTH) - 64'd1);

   // configuration
   logic              enabled_ff;
   logic [WORD_W-1:0] mask_ff, fpc_ff, boot_ff;
   // time state
   logic [WORD_W-1:0] off_sec_ff, off_sec_in, off_frac_ff, off_frac_in;
   logic [WORD_W-1:0] last_ff, last_in;
   // per-transaction working registers
   req_code_type      req_ff;
   logic [WORD_W-1:0] now_ff, delta_ff;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [2*WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] sec_ff, sec_in, frac_ff, frac_in;
   logic              carry_ff, carry_in;
   logic [WORD_W-1:0] ns_acc_ff, ns_acc_in, us_acc_ff, us_acc_in;
   logic [HALF_W-1:0] mul_a, mul_b;
   logic [WORD_W:0]   frac_sum;
   logic [2*WORD_W-1:0] prod_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         mask_ff    <= {WORD_W{1'b1}};
         fpc_ff     <= '0;
         boot_ff    <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_COUNTER_ENABLED: enabled_ff <= csr_write_data[0];
            CSR_COUNTER_MASK:    mask_ff    <= csr_write_data;
            CSR_FRAC_PER_COUNT:  fpc_ff     <= csr_write_data;
            CSR_BOOT_SECONDS:    boot_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_sec_ff  <= '0;
         off_frac_ff <= '0;
         last_ff     <= '0;
      end else begin
         off_sec_ff  <= off_sec_in;
         off_frac_ff <= off_frac_in;
         last_ff     <= last_in;
      end
   end

   // state is only touched at the finish step of an enabled tick or latch
   always_comb begin
      off_sec_in  = off_sec_ff;
      off_frac_in = off_frac_ff;
      last_in     = last_ff;
      if (cmd.finish && enabled_ff) begin
         if (req_ff == REQ_TICK) begin
            off_sec_in  = sec_ff;
            off_frac_in = frac_ff;
            last_in     = now_ff;
         end else if (req_ff == REQ_LATCH) begin
            last_in = now_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_code_type'(in_req_type);
         now_ff <= in_counter_now & WidthMask;
      end
      if (cmd.delta) begin
         // a latch sums a zero delta, which returns the stored offset
         if (req_ff == REQ_LATCH) begin
            delta_ff <= '0;
         end else begin
            delta_ff <= (now_ff - last_ff) & mask_ff & WidthMask;
         end
      end
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      sec_ff    <= sec_in;
      frac_ff   <= frac_in;
      carry_ff  <= carry_in;
      ns_acc_ff <= ns_acc_in;
      us_acc_ff <= us_acc_in;
      if (cmd.out_load) begin
         out_time_seconds  <= sec_ff;
         out_time_fraction <= frac_ff;
         out_nanoseconds   <= ns_acc_ff[HALF_W+NS_W-1:HALF_W];
         out_microseconds  <= us_acc_ff[HALF_W+US_W-1:HALF_W];
      end
   end

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         MUL_LL: begin
            mul_a = delta_ff[HALF_W-1:0];
            mul_b = fpc_ff[HALF_W-1:0];
         end
         MUL_LH: begin
            mul_a = delta_ff[HALF_W-1:0];
            mul_b = fpc_ff[WORD_W-1:HALF_W];
         end
         MUL_HL: begin
            mul_a = delta_ff[WORD_W-1:HALF_W];
            mul_b = fpc_ff[HALF_W-1:0];
         end
         MUL_HH: begin
            mul_a = delta_ff[WORD_W-1:HALF_W];
            mul_b = fpc_ff[WORD_W-1:HALF_W];
         end
         MUL_NS_LO: begin
            mul_a = frac_ff[HALF_W-1:0];
            mul_b = NS_SCALE;
         end
         MUL_NS_HI: begin
            mul_a = frac_ff[WORD_W-1:HALF_W];
            mul_b = NS_SCALE;
         end
         MUL_US_LO: begin
            mul_a = frac_ff[HALF_W-1:0];
            mul_b = US_SCALE;
         end
         MUL_US_HI: begin
            mul_a = frac_ff[WORD_W-1:HALF_W];
            mul_b = US_SCALE;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
   end

   // 128-bit product accumulator, partial products land at 0, 32 or 64
   always_comb begin
      prod_ext = {{WORD_W{1'b0}}, prod_ff};
      case (cmd.acc_op)
         ACC_CLEAR: acc_in = '0;
         ACC_ADD0:  acc_in = acc_ff + prod_ext;
         ACC_ADD32: acc_in = acc_ff + (prod_ext << HALF_W);
         ACC_ADD64: acc_in = acc_ff + (prod_ext << WORD_W);
         default:   acc_in = acc_ff;
      endcase
   end

   always_comb begin
      frac_sum = {1'b0, off_frac_ff} + {1'b0, acc_ff[WORD_W-1:0]};
      sec_in   = sec_ff;
      frac_in  = frac_ff;
      carry_in = carry_ff;
      if (cmd.sum_frac) begin
         frac_in  = frac_sum[WORD_W-1:0];
         carry_in = frac_sum[WORD_W];
      end
      if (cmd.sum_sec) begin
         sec_in = off_sec_ff + acc_ff[2*WORD_W-1:WORD_W] + {{(WORD_W-1){1'b0}}, carry_ff};
      end
      if (cmd.finish) begin
         if (!enabled_ff) begin
            sec_in  = '0;
            frac_in = '0;
         end else if (req_ff == REQ_WALL) begin
            sec_in = sec_ff + boot_ff;
         end
      end
   end

   // floor(frac * scale / 2^64) = (hi*scale + ((lo*scale) >> 32)) >> 32
   always_comb begin
      ns_acc_in = ns_acc_ff;
      us_acc_in = us_acc_ff;
      case (cmd.cvt_op)
         CVT_NS_LO: ns_acc_in = {{HALF_W{1'b0}}, prod_ff[WORD_W-1:HALF_W]};
         CVT_NS_HI: ns_acc_in = ns_acc_ff + prod_ff;
         CVT_US_LO: us_acc_in = {{HALF_W{1'b0}}, prod_ff[WORD_W-1:HALF_W]};
         CVT_US_HI: us_acc_in = us_acc_ff + prod_ff;
         default: ;
      endcase
   end

endmodule

FILE: rtl/binary_time_counter_accumulator_top.sv
// Binary time counter accumulator, top level: controller plus datapath.
// One request in flight: a new request is taken only once the previous result is
// loaded into the output register, which waits while an earlier result is held. The
// sequence runs through one shared 32x32 multiplier doing four partial products and
// four conversion products in turn. Reset (synchronous, active high) clears offsets,
// last sample and configuration registers to their defaults; no clearing pass is needed.
module binary_time_counter_accumulator_top #(
   parameter int COUNTER_WIDTH = btca_pkg::DEFAULT_COUNTER_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   btca_req_if.sink                         req,
   btca_rsp_if.source                       rsp,
   input  logic                             csr_write_enable,
   input  logic [btca_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [btca_pkg::WORD_W-1:0]      csr_write_data
);
   import btca_pkg::*;

   cmd_type cmd;

   btca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   btca_datapath #(
      .COUNTER_WIDTH (COUNTER_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .in_req_type       (req.req_type),
      .in_counter_now    (req.counter_now),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .out_time_seconds  (rsp.time_seconds),
      .out_time_fraction (rsp.time_fraction),
      .out_nanoseconds   (rsp.nanoseconds),
      .out_microseconds  (rsp.microseconds)
   );

endmodule

FILE: verif/btca_time_checker.sv
// btca_time_checker: watches the request, result and register ports of the time
// counter accumulator, predicts every result and compares it field by field
// depends on btca_pkg for widths, request codes and register indexes
module btca_time_checker #(
   parameter int COUNTER_WIDTH = btca_pkg::DEFAULT_COUNTER_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic [btca_pkg::REQ_W-1:0]       req_type,
   input  logic [btca_pkg::WORD_W-1:0]      counter_now,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic [btca_pkg::WORD_W-1:0]      time_seconds,
   input  logic [btca_pkg::WORD_W-1:0]      time_fraction,
   input  logic [btca_pkg::NS_W-1:0]        nanoseconds,
   input  logic [btca_pkg::US_W-1:0]        microseconds,
   input  logic                             csr_write_enable,
   input  logic [btca_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [btca_pkg::WORD_W-1:0]      csr_write_data,
   output int                               fail_count,
   output int                               pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import btca_pkg::*;

   localparam logic [WORD_W-1:0] COUNT_MASK = (COUNTER_WIDTH >= WORD_W) ? {WORD_W{1'b1}} :
                                              ((64'd1 << COUNTER_WIDTH) - 64'd1);

   typedef struct packed {
      logic [WORD_W-1:0] seconds;
      logic [WORD_W-1:0] fraction;
      logic [NS_W-1:0]   ns;
      logic [US_W-1:0]   us;
   } time_reading_type;

   logic              timekeeping_on;
   logic [WORD_W-1:0] delta_mask;
   logic [WORD_W-1:0] count_scale;
   logic [WORD_W-1:0] boot_sec;
   logic [WORD_W-1:0] offset_sec;
   logic [WORD_W-1:0] offset_frac;
   logic [WORD_W-1:0] last_sample;
   time_reading_type  readings_due[$];
   int                mismatches = 0;

   assign fail_count = mismatches;

   // applies one request to the tracked offset and returns the reading it yields
   function automatic time_reading_type advance_and_read(input logic [REQ_W-1:0] kind,
                                                         input logic [WORD_W-1:0] raw);
      logic [WORD_W-1:0]   now;
      logic [WORD_W-1:0]   delta;
      logic [WORD_W-1:0]   sum_sec;
      logic [2*WORD_W-1:0] product;
      logic [WORD_W:0]     frac_sum;
      logic [95:0]         ns_wide;
      logic [95:0]         us_wide;
      time_reading_type    r;
      r = '0;
      now = raw & COUNT_MASK;
      if (timekeeping_on) begin
         delta = (now - last_sample) & delta_mask & COUNT_MASK;
         product = {64'd0, delta} * {64'd0, count_scale};
         frac_sum = {1'b0, offset_frac} + {1'b0, product[WORD_W-1:0]};
         sum_sec = offset_sec + product[2*WORD_W-1:WORD_W] + {63'd0, frac_sum[WORD_W]};
         case (req_code_type'(kind))
            REQ_TICK: begin
               offset_sec = sum_sec;
               offset_frac = frac_sum[WORD_W-1:0];
               last_sample = now;
               r.seconds = offset_sec;
               r.fraction = offset_frac;
            end
            REQ_UPTIME: begin
               r.seconds = sum_sec;
               r.fraction = frac_sum[WORD_W-1:0];
            end
            REQ_WALL: begin
               r.seconds = sum_sec + boot_sec;
               r.fraction = frac_sum[WORD_W-1:0];
            end
            default: begin
               // counter switch: new sample, offset untouched
               last_sample = now;
               r.seconds = offset_sec;
               r.fraction = offset_frac;
            end
         endcase
         ns_wide = {32'd0, r.fraction} * {64'd0, NS_SCALE};
         us_wide = {32'd0, r.fraction} * {64'd0, US_SCALE};
         r.ns = ns_wide[WORD_W +: NS_W];
         r.us = us_wide[WORD_W +: US_W];
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      time_reading_type want;
      if (reset) begin
         timekeeping_on = 1'b0;
         delta_mask = {WORD_W{1'b1}};
         count_scale = '0;
         boot_sec = '0;
         offset_sec = '0;
         offset_frac = '0;
         last_sample = '0;
         readings_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_COUNTER_ENABLED: timekeeping_on = csr_write_data[0];
               CSR_COUNTER_MASK:    delta_mask = csr_write_data;
               CSR_FRAC_PER_COUNT:  count_scale = csr_write_data;
               CSR_BOOT_SECONDS:    boot_sec = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (readings_due.size() == 0) begin
               $error("result transaction with nothing outstanding: seconds %h fraction %h",
                      time_seconds, time_fraction);
               mismatches++;
            end else begin
               want = readings_due.pop_front();
               check_field("time_seconds", want.seconds, time_seconds);
               check_field("time_fraction", want.fraction, time_fraction);
               check_field("nanoseconds", 64'(want.ns), 64'(nanoseconds));
               check_field("microseconds", 64'(want.us), 64'(microseconds));
            end
         end
         if (req_valid && req_ready)
            readings_due.push_back(advance_and_read(req_type, counter_now));
      end
      pending <= readings_due.size();
   end

endmodule

FILE: verif/tb_binary_time_counter_accumulator_top.sv
// tb_binary_time_counter_accumulator_top: clock, reset, register setup and traffic
// for the time counter accumulator; verdict taken from btca_time_checker
// depends on btca_pkg, btca_req_if, btca_rsp_if and the block itself
module tb_binary_time_counter_accumulator_top;
   timeunit 1ns;
   timeprecision 1ps;
   import btca_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [WORD_W-1:0]      csr_write_data;
   int                     fail_count;
   int                     pending;
   bit                     no_idle = 1'b0;
   bit                     hold_off_request = 1'b0;

   localparam logic [WORD_W-1:0] ALL_ONES = {WORD_W{1'b1}};

   btca_req_if req_ch();
   btca_rsp_if rsp_ch();

   binary_time_counter_accumulator_top uut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   btca_time_checker time_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_type         (req_ch.req_type),
      .counter_now      (req_ch.counter_now),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .time_seconds     (rsp_ch.time_seconds),
      .time_fraction    (rsp_ch.time_fraction),
      .nanoseconds      (rsp_ch.nanoseconds),
      .microseconds     (rsp_ch.microseconds),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic send_item(input req_code_type kind, input logic [WORD_W-1:0] now);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.counter_now <= now;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // stop offering and wait until every result is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic enable, input logic [WORD_W-1:0] mask,
                             input logic [WORD_W-1:0] scale, input logic [WORD_W-1:0] boot);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_COUNTER_ENABLED;
      csr_write_data <= {63'd0, enable};
      @(posedge clock);
      csr_index <= CSR_COUNTER_MASK;
      csr_write_data <= mask;
      @(posedge clock);
      csr_index <= CSR_FRAC_PER_COUNT;
      csr_write_data <= scale;
      @(posedge clock);
      csr_index <= CSR_BOOT_SECONDS;
      csr_write_data <= boot;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 14);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = 300;
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      logic [WORD_W-1:0] hw_count;
      logic [WORD_W-1:0] now;
      logic [WORD_W-1:0] mask_sel;
      logic [WORD_W-1:0] scale_sel;
      logic [WORD_W-1:0] boot_sel;
      logic [127:0]      one_second;
      logic              enable_sel;
      req_code_type      kind;
      int                items;
      int                width;
      int                pick;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_TICK;
      req_ch.counter_now = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_COUNTER_ENABLED;
      csr_write_data = '0;
      one_second = 128'd1 << 64;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // counter not attached yet: every request reads zero
      send_item(REQ_TICK, '0);
      send_item(REQ_UPTIME, ALL_ONES);
      send_item(REQ_WALL, ALL_ONES);
      send_item(REQ_LATCH, rand_word());

      // largest scale and boot offset: products and sums wrap
      drain();
      set_config(1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
      send_item(REQ_LATCH, '0);
      send_item(REQ_TICK, ALL_ONES);
      send_item(REQ_UPTIME, '0);
      send_item(REQ_WALL, '0);
      send_item(REQ_TICK, 64'd1);
      send_item(REQ_TICK, 64'd2);
      send_item(REQ_LATCH, ALL_ONES);
      send_item(REQ_UPTIME, ALL_ONES);
      send_item(REQ_WALL, 64'd5);

      // zero mask kills every delta
      drain();
      set_config(1'b1, '0, 64'd123456789, '0);
      send_item(REQ_TICK, rand_word());
      send_item(REQ_UPTIME, rand_word());

      // zero scale, narrow counter
      drain();
      set_config(1'b1, 64'hFFFF, '0, 64'd1);
      send_item(REQ_TICK, 64'h1234_5678);
      send_item(REQ_WALL, ALL_ONES);

      hw_count = rand_word();
      for (int phase = 0; phase < 10; phase++) begin
         no_idle = (phase % 4 == 1);
         width = $urandom_range(16, 64);
         enable_sel = 1'b1;
         mask_sel = (width == 64) ? ALL_ONES : ((64'd1 << width) - 64'd1);
         scale_sel = (phase % 2 == 0) ? 64'(one_second / $urandom_range(1000, 2000000000))
                                      : rand_word();
         boot_sel = rand_word();
         case (phase)
            0: mask_sel = ALL_ONES;
            1: begin
               mask_sel = 64'hFFFF_FFFF;
               boot_sel = ALL_ONES;
            end
            2: enable_sel = 1'b0;
            3: begin
               scale_sel = ALL_ONES;
               boot_sel = '0;
            end
            4: mask_sel = '0;
            default: ;
         endcase
         items = (phase == 2 || phase == 4) ? 30 : 110;
         drain();
         set_config(enable_sel, mask_sel, scale_sel, boot_sel);
         if (phase == 3)
            hold_off_request = 1'b1;
         send_item(REQ_LATCH, hw_count);
         for (int n = 1; n < items; n++) begin
            if ($urandom_range(0, 99) < 85) begin
               pick = $urandom_range(0, 99);
               if (pick < 70)
                  hw_count = hw_count + 64'($urandom_range(0, 3000));
               else if (pick < 85)
                  hw_count = hw_count + 64'($urandom);
               else if (pick < 95)
                  hw_count = hw_count + rand_word();
               pick = $urandom_range(0, 19);
               if (pick < 8)
                  kind = REQ_TICK;
               else if (pick < 13)
                  kind = REQ_UPTIME;
               else if (pick < 18)
                  kind = REQ_WALL;
               else begin
                  // switch to a different counter source
                  kind = REQ_LATCH;
                  hw_count = rand_word();
               end
               now = hw_count;
            end else begin
               kind = req_code_type'($urandom_range(0, 3));
               now = rand_word();
            end
            send_item(kind, now);
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("tb_binary_time_counter_accumulator_top: PASS");
      else
         $display("tb_binary_time_counter_accumulator_top: FAIL");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("tb_binary_time_counter_accumulator_top: FAIL");
      $finish;
   end

endmodule
